// ----- src/bounded_catch_up_refresh_scheduler_top_assert.svh -----
// Assertion macros used by the refresh scheduler top module.
`ifndef BOUNDED_CATCH_UP_REFRESH_SCHEDULER_TOP_ASSERT_SVH
`define BOUNDED_CATCH_UP_REFRESH_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define BCURS_ASSERT_NOW(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define BCURS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bcurs_pkg.sv -----
// Types and constants of the bounded catch-up refresh scheduler.
package bcurs_pkg;

    localparam int RATE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DUE_W      = 8;
    localparam int DROP_W     = 25;
    localparam int DEFER_W    = 8;
    localparam int ALPHA_W    = 25;
    localparam int GPHASE_W   = 32;
    localparam int VPHASE_W   = 25;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_RESET   = 1'b1
    } t_op;

    typedef enum logic {
        POLICY_DROP     = 1'b0,
        POLICY_PRESERVE = 1'b1
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GUEST_RATE  = 3'd0,
        CFG_VISUAL_RATE = 3'd1,
        CFG_POLICY      = 3'd2,
        CFG_MAX_DUE     = 3'd3,
        CFG_MAX_DEFER   = 3'd4
    } t_cfg_idx;

    localparam logic [RATE_W-1:0]  RST_GUEST_RATE  = 16'd60;
    localparam logic [RATE_W-1:0]  RST_VISUAL_RATE = 16'd60;
    localparam logic [DUE_W-1:0]   RST_MAX_DUE     = 8'd4;
    localparam logic [DEFER_W-1:0] RST_MAX_DEFER   = 8'd1;

    typedef struct packed {
        logic [RATE_W-1:0]  guest_rate;
        logic [RATE_W-1:0]  visual_rate;
        t_policy            policy;
        logic [DUE_W-1:0]   max_due;
        logic [DEFER_W-1:0] max_defer;
    } t_cfg;

    typedef struct packed {
        logic [GPHASE_W-1:0] guest_phase;
        logic [VPHASE_W-1:0] visual_phase;
        logic                started;
    } t_state;

    typedef struct packed {
        logic [DUE_W-1:0]    refreshes_due;
        logic [DROP_W-1:0]   dropped_refreshes;
        logic [DEFER_W-1:0]  deferred_refreshes;
        logic [ALPHA_W-1:0]  interpolation_alpha;
        logic [GPHASE_W-1:0] guest_phase_out;
        logic [VPHASE_W-1:0] visual_phase_out;
    } t_result;

endpackage

// ----- src/bcurs_in_if.sv -----
// Input channel: advance or reset items with elapsed time.
interface bcurs_in_if #(
    parameter int ELAPSED_BITS = 32
);
    logic                    valid;
    logic                    ready;
    bcurs_pkg::t_op          op;
    logic [ELAPSED_BITS-1:0] elapsed_time;

    modport source (output valid, output op, output elapsed_time, input ready);
    modport sink   (input valid, input op, input elapsed_time, output ready);
endinterface

// ----- src/bcurs_out_if.sv -----
// Output channel: one scheduling result item per input item.
interface bcurs_out_if;
    logic                                valid;
    logic                                ready;
    logic [bcurs_pkg::DUE_W-1:0]         refreshes_due;
    logic [bcurs_pkg::DROP_W-1:0]        dropped_refreshes;
    logic [bcurs_pkg::DEFER_W-1:0]       deferred_refreshes;
    logic [bcurs_pkg::ALPHA_W-1:0]       interpolation_alpha;
    logic [bcurs_pkg::GPHASE_W-1:0]      guest_phase_out;
    logic [bcurs_pkg::VPHASE_W-1:0]      visual_phase_out;

    modport source (
        output valid, output refreshes_due, output dropped_refreshes,
        output deferred_refreshes, output interpolation_alpha,
        output guest_phase_out, output visual_phase_out, input ready
    );
    modport sink (
        input valid, input refreshes_due, input dropped_refreshes,
        input deferred_refreshes, input interpolation_alpha,
        input guest_phase_out, input visual_phase_out, output ready
    );
endinterface

// ----- src/bcurs_cfg.sv -----
// Configuration register file of the refresh scheduler.
module bcurs_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bcurs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcurs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bcurs_pkg::t_cfg                 o_cfg
);
    import bcurs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.guest_rate  <= RST_GUEST_RATE;
            r_cfg.visual_rate <= RST_VISUAL_RATE;
            r_cfg.policy      <= POLICY_DROP;
            r_cfg.max_due     <= RST_MAX_DUE;
            r_cfg.max_defer   <= RST_MAX_DEFER;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GUEST_RATE:  r_cfg.guest_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_VISUAL_RATE: r_cfg.visual_rate <= i_cfg_data[RATE_W-1:0];
                CFG_POLICY:      r_cfg.policy      <= t_policy'(i_cfg_data[0]);
                CFG_MAX_DUE:     r_cfg.max_due     <= i_cfg_data[DUE_W-1:0];
                CFG_MAX_DEFER:   r_cfg.max_defer   <= i_cfg_data[DEFER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ----- src/bcurs_step.sv -----
// Combinational step logic: phase accumulation, catch-up capping and alpha.
module bcurs_step #(
    parameter int FRACTION_BITS = 24,
    parameter int ELAPSED_BITS  = 32
) (
    input  bcurs_pkg::t_op          i_op,
    input  logic [ELAPSED_BITS-1:0] i_elapsed,
    input  bcurs_pkg::t_state       i_state,
    input  bcurs_pkg::t_cfg         i_cfg,
    output bcurs_pkg::t_state       o_state_next,
    output bcurs_pkg::t_result      o_result
);
    import bcurs_pkg::*;

    localparam int PROD_W  = ELAPSED_BITS + RATE_W;
    // The accumulation wraps at SUM_W bits, which is capped at 64.
    localparam int SUM_W   = (PROD_W + 1 > 64) ? 64 : PROD_W + 1;
    localparam int WHOLE_W = SUM_W - FRACTION_BITS;
    localparam int EXT_W   = (WHOLE_W > DUE_W) ? WHOLE_W : DUE_W;
    localparam logic [SUM_W-1:0] ONE_FX    = SUM_W'(1) << FRACTION_BITS;
    localparam logic [SUM_W-1:0] FRAC_MASK = ONE_FX - SUM_W'(1);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ONE_FX[ALPHA_W-1:0];

    logic [PROD_W-1:0]  g_prod;
    logic [PROD_W-1:0]  v_prod;
    logic [SUM_W-1:0]   g_sum;
    logic [SUM_W-1:0]   v_sum;
    logic [SUM_W-1:0]   g_next;
    logic [EXT_W-1:0]   whole;
    logic [EXT_W-1:0]   cap_due;
    logic [EXT_W-1:0]   cap_defer;
    logic [EXT_W-1:0]   due;
    logic [EXT_W-1:0]   remaining;
    logic [EXT_W-1:0]   dropped;
    logic [EXT_W-1:0]   deferred;
    logic               v_carry;
    logic               drop_any;
    logic [VPHASE_W-1:0] v_next;
    logic [ALPHA_W-1:0]  alpha;

    always_comb begin
        g_prod = PROD_W'(i_elapsed) * PROD_W'(i_cfg.guest_rate);
        v_prod = PROD_W'(i_elapsed) * PROD_W'(i_cfg.visual_rate);
        g_sum  = SUM_W'(i_state.guest_phase) + SUM_W'(g_prod);
        v_sum  = SUM_W'(i_state.visual_phase) + SUM_W'(v_prod);

        whole     = EXT_W'(g_sum[SUM_W-1:FRACTION_BITS]);
        cap_due   = EXT_W'(i_cfg.max_due);
        cap_defer = EXT_W'(i_cfg.max_defer);
        due       = (whole < cap_due) ? whole : cap_due;
        remaining = whole - due;

        if (i_cfg.policy == POLICY_PRESERVE) begin
            if (remaining > cap_defer) begin
                dropped  = remaining - cap_defer;
                deferred = cap_defer;
            end else begin
                dropped  = '0;
                deferred = remaining;
            end
        end else begin
            dropped  = remaining;
            deferred = '0;
        end

        // Whatever is kept as debt sits above the fraction of the guest phase.
        g_next   = (SUM_W'(deferred[DEFER_W-1:0]) << FRACTION_BITS) | (g_sum & FRAC_MASK);
        v_carry  = |v_sum[SUM_W-1:FRACTION_BITS];
        drop_any = |dropped;
        v_next   = drop_any ? '0 : v_sum[VPHASE_W-1:0] & FRAC_MASK[VPHASE_W-1:0];
        alpha    = (drop_any || v_carry) ? ALPHA_ONE : v_next;
    end

    always_comb begin
        priority if (i_op == OP_RESET) begin
            o_state_next = '0;
            o_result     = '0;
        end else if (!i_state.started) begin
            o_state_next         = i_state;
            o_state_next.started = 1'b1;
            o_result                     = '0;
            o_result.refreshes_due       = DUE_W'(1);
            o_result.interpolation_alpha = ALPHA_ONE;
            o_result.guest_phase_out     = i_state.guest_phase;
            o_result.visual_phase_out    = i_state.visual_phase;
        end else begin
            o_state_next.guest_phase  = g_next[GPHASE_W-1:0];
            o_state_next.visual_phase = v_next;
            o_state_next.started      = 1'b1;
            o_result.refreshes_due       = due[DUE_W-1:0];
            o_result.dropped_refreshes   = DROP_W'(dropped);
            o_result.deferred_refreshes  = deferred[DEFER_W-1:0];
            o_result.interpolation_alpha = alpha;
            o_result.guest_phase_out     = g_next[GPHASE_W-1:0];
            o_result.visual_phase_out    = v_next;
        end
    end
endmodule

// ----- src/bounded_catch_up_refresh_scheduler_top.sv -----
// Bounded catch-up refresh scheduler: each item moves from an input register
// through the step logic into a result register, and one item is taken every
// cycle while the result side keeps up. This rate is set by the phase update:
// multiply by the rate, add to the stored phase, cap and split, all between
// the input register and the phase and result registers, so the next item
// always sees the updated phases. Configuration writes take effect on the
// following cycle.
module bounded_catch_up_refresh_scheduler_top #(
    parameter int FRACTION_BITS = 24,
    parameter int ELAPSED_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bcurs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcurs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bcurs_in_if.sink                         i_in,
    bcurs_out_if.source                      o_out
);
    import bcurs_pkg::*;

    `include "bounded_catch_up_refresh_scheduler_top_assert.svh"

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(64'd1 << FRACTION_BITS);

    t_cfg                    cfg;
    logic                    r_s1_valid;
    t_op                     r_s1_op;
    logic [ELAPSED_BITS-1:0] r_s1_elapsed;
    logic                    r_out_valid;
    t_result                 r_res;
    t_result                 n_res;
    t_state                  r_state;
    t_state                  n_state;
    logic                    s1_adv;
    logic                    in_acc;

    bcurs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcurs_step #(
        .FRACTION_BITS (FRACTION_BITS),
        .ELAPSED_BITS  (ELAPSED_BITS)
    ) u_step (
        .i_op         (r_s1_op),
        .i_elapsed    (r_s1_elapsed),
        .i_state      (r_state),
        .i_cfg        (cfg),
        .o_state_next (n_state),
        .o_result     (n_res)
    );

    // The input register drains whenever the result register is empty or
    // its item is being taken in the same cycle.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op      <= i_in.op;
            r_s1_elapsed <= i_in.elapsed_time;
        end
        if (s1_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.refreshes_due       = r_res.refreshes_due;
    assign o_out.dropped_refreshes   = r_res.dropped_refreshes;
    assign o_out.deferred_refreshes  = r_res.deferred_refreshes;
    assign o_out.interpolation_alpha = r_res.interpolation_alpha;
    assign o_out.guest_phase_out     = r_res.guest_phase_out;
    assign o_out.visual_phase_out    = r_res.visual_phase_out;

    `BCURS_ASSERT_NEXT(a_phase_matches_result, s1_adv, r_res.guest_phase_out == r_state.guest_phase && r_res.visual_phase_out == r_state.visual_phase, "result phases differ from stored phases")
    `BCURS_ASSERT_NOW(a_drop_forces_alpha, r_out_valid && r_res.dropped_refreshes != '0, r_res.interpolation_alpha == ALPHA_ONE && r_res.visual_phase_out == '0, "dropped refreshes without full alpha and cleared visual phase")
    `BCURS_ASSERT_NEXT(a_reset_item_clears, s1_adv && r_s1_op == OP_RESET, !r_state.started && r_state.guest_phase == '0 && r_state.visual_phase == '0, "reset item did not clear the state")
    `BCURS_ASSERT_NEXT(a_advance_starts, s1_adv && r_s1_op == OP_ADVANCE, r_state.started, "advance item left the scheduler unstarted")
endmodule
